// File: sv/stt_pkg.sv
package stt_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] KIND_FUNCTION   = 3'd0;
    localparam logic [2:0] KIND_LOOP       = 3'd1;
    localparam logic [2:0] KIND_KEYWORD    = 3'd2;
    localparam logic [2:0] KIND_IDENTIFIER = 3'd3;
    localparam logic [2:0] KIND_NUMBER     = 3'd4;
    localparam logic [2:0] KIND_OPERATOR   = 3'd5;
    localparam logic [2:0] KIND_SYMBOL     = 3'd6;
    localparam logic [2:0] KIND_UNKNOWN    = 3'd7;

    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;

    localparam int NUM_KW = 5;

    // Keywords, left-justified with zero padding.
    localparam logic [63:0] KW_TEXT [NUM_KW] = '{
        "function",
        {"for", 40'h0},
        {"while", 24'h0},
        {"return", 16'h0},
        {"if", 48'h0}
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd8, 4'd3, 4'd5, 4'd6, 4'd2};
    localparam logic [2:0] KW_KIND [NUM_KW] = '{
        KIND_FUNCTION, KIND_LOOP, KIND_LOOP, KIND_KEYWORD, KIND_KEYWORD
    };

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  first;
        logic [7:0]  second;
        logic [15:0] length;
        logic [15:0] line;
        logic [15:0] column;
    } t_token;

    // Everything one source byte produces: one or two tokens.
    typedef struct packed {
        logic   two;
        t_token tok1;
        t_token tok0;
    } t_record;

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c inside {8'h20, [8'h09:8'h0D]});
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        return (c inside {8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D, 8'h3C, 8'h3E});
    endfunction

    function automatic logic is_sym(input logic [7:0] c);
        return (c inside {8'h7B, 8'h7D, 8'h28, 8'h29, 8'h3B});
    endfunction

    function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
        logic [63:0] s;
        s = KW_TEXT[k] << {pos, 3'b000};
        return s[63:56];
    endfunction

    // Drop every keyword that cannot have byte c at position pos.
    function automatic logic [NUM_KW-1:0] narrow(input logic [NUM_KW-1:0] cand,
                                                 input logic [3:0] pos,
                                                 input logic [7:0] c);
        logic [NUM_KW-1:0] res;
        res = cand;
        for (int k = 0; k < NUM_KW; k++) begin
            if (pos >= KW_LEN[k] || kw_char(k, pos[2:0]) != c) begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

endpackage

// File: sv/stt_front.sv
module stt_front #(
    parameter int COUNT_WIDTH = stt_pkg::COUNT_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_character,
    input  logic             i_end_of_text,
    output logic             o_rec_valid,
    output stt_pkg::t_record o_rec
);

    localparam int CW = COUNT_WIDTH;

    typedef enum logic [1:0] {MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_OPER} t_mode;

    t_mode                        r_mode, n_mode;
    logic                         r_seen, n_seen;
    logic [CW-1:0]                r_line, n_line;
    logic [CW-1:0]                r_col, n_col;
    logic [CW-1:0]                r_tline, n_tline;
    logic [CW-1:0]                r_tcol, n_tcol;
    logic [CW-1:0]                r_run, n_run;
    logic [stt_pkg::NUM_KW-1:0]   r_cand, n_cand;
    logic [7:0]                   r_held, n_held;

    logic [1:0]                   cnt;
    stt_pkg::t_token              toks [2];
    logic                         done;
    logic [7:0]                   c;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v == {CW{1'b1}}) ? v : v + CW'(1);
    endfunction

    function automatic logic [15:0] sat16(input logic [CW-1:0] v);
        logic [31:0] e;
        e = 32'(v);
        return (e > 32'h0000FFFF) ? 16'hFFFF : e[15:0];
    endfunction

    function automatic stt_pkg::t_token make_tok(input logic [2:0] kind,
                                                 input logic [7:0] first,
                                                 input logic [7:0] second,
                                                 input logic [CW-1:0] len,
                                                 input logic [CW-1:0] ln,
                                                 input logic [CW-1:0] cl);
        stt_pkg::t_token t;
        t.kind   = kind;
        t.first  = first;
        t.second = second;
        t.length = sat16(len);
        t.line   = sat16(ln);
        t.column = sat16(cl);
        return t;
    endfunction

    // Token for the run in progress; the caller checks that a run is open.
    function automatic stt_pkg::t_token flush_tok(input t_mode m,
                                                  input logic [7:0] held,
                                                  input logic [CW-1:0] run,
                                                  input logic [stt_pkg::NUM_KW-1:0] cand,
                                                  input logic [CW-1:0] tl,
                                                  input logic [CW-1:0] tc);
        logic [2:0] kind;
        logic       found;
        logic [CW-1:0] len;
        kind  = stt_pkg::KIND_IDENTIFIER;
        found = 1'b0;
        len   = run;
        for (int k = 0; k < stt_pkg::NUM_KW; k++) begin
            if (!found && cand[k] && run == CW'(stt_pkg::KW_LEN[k])) begin
                kind  = stt_pkg::KW_KIND[k];
                found = 1'b1;
            end
        end
        case (m)
            MODE_NUMBER: kind = stt_pkg::KIND_NUMBER;
            MODE_OPER: begin
                kind = stt_pkg::KIND_OPERATOR;
                len  = CW'(1);
            end
            default: ;
        endcase
        return make_tok(kind, held, 8'h00, len, tl, tc);
    endfunction

    assign c = i_character;

    always_comb begin
        n_mode  = r_mode;
        n_seen  = r_seen;
        n_line  = r_line;
        n_col   = r_col;
        n_tline = r_tline;
        n_tcol  = r_tcol;
        n_run   = r_run;
        n_cand  = r_cand;
        n_held  = r_held;
        cnt     = 2'd0;
        toks[0] = '0;
        toks[1] = '0;
        done    = 1'b0;

        // Extend or close the run in progress.
        case (r_mode)
            MODE_IDENT: begin
                if (stt_pkg::is_letter(c) || c == stt_pkg::CH_UNDERSCORE) begin
                    if (r_run < CW'(16)) begin
                        n_cand = stt_pkg::narrow(r_cand, r_run[3:0], c);
                    end else begin
                        n_cand = '0;
                    end
                    n_run = sat_inc(r_run);
                    done  = 1'b1;
                end else begin
                    toks[0] = flush_tok(r_mode, r_held, r_run, r_cand, r_tline, r_tcol);
                    cnt     = 2'd1;
                    n_mode  = MODE_IDLE;
                end
            end
            MODE_NUMBER: begin
                if (stt_pkg::is_digit(c)) begin
                    n_run = sat_inc(r_run);
                    done  = 1'b1;
                end else begin
                    toks[0] = flush_tok(r_mode, r_held, r_run, r_cand, r_tline, r_tcol);
                    cnt     = 2'd1;
                    n_mode  = MODE_IDLE;
                end
            end
            MODE_OPER: begin
                if (c == stt_pkg::CH_EQUAL || (c == r_held &&
                    (r_held == stt_pkg::CH_PLUS || r_held == stt_pkg::CH_MINUS))) begin
                    toks[0] = make_tok(stt_pkg::KIND_OPERATOR, r_held, c, CW'(2),
                                       r_tline, r_tcol);
                    cnt     = 2'd1;
                    n_mode  = MODE_IDLE;
                    done    = 1'b1;
                end else begin
                    toks[0] = flush_tok(r_mode, r_held, r_run, r_cand, r_tline, r_tcol);
                    cnt     = 2'd1;
                    n_mode  = MODE_IDLE;
                end
            end
            default: ;
        endcase

        // Start a new token with this byte.
        if (!done) begin
            if (stt_pkg::is_space(c)) begin
                // Whitespace makes no token.
            end else if (stt_pkg::is_letter(c) || stt_pkg::is_digit(c) ||
                         stt_pkg::is_oper(c)) begin
                n_mode  = stt_pkg::is_letter(c) ? MODE_IDENT :
                          stt_pkg::is_digit(c)  ? MODE_NUMBER : MODE_OPER;
                n_held  = c;
                n_tline = r_line;
                n_tcol  = r_col;
                n_run   = CW'(1);
                n_cand  = stt_pkg::is_letter(c) ?
                          stt_pkg::narrow('1, 4'd0, c) : '1;
            end else begin
                toks[cnt[0]] = make_tok(stt_pkg::is_sym(c) ? stt_pkg::KIND_SYMBOL
                                                          : stt_pkg::KIND_UNKNOWN,
                                        c, 8'h00, CW'(1), r_line, r_col);
                cnt = cnt + 2'd1;
            end
        end

        // Position tracking; leading whitespace is not counted.
        n_seen = r_seen | ~stt_pkg::is_space(c);
        if (n_seen) begin
            if (c == stt_pkg::CH_NEWLINE) begin
                n_line = sat_inc(r_line);
                n_col  = CW'(1);
            end else begin
                n_col = sat_inc(r_col);
            end
        end

        if (i_end_of_text) begin
            if (n_mode != MODE_IDLE) begin
                toks[cnt[0]] = flush_tok(n_mode, n_held, n_run, n_cand, n_tline, n_tcol);
                cnt = cnt + 2'd1;
            end
            n_mode  = MODE_IDLE;
            n_seen  = 1'b0;
            n_line  = CW'(1);
            n_col   = CW'(1);
            n_tline = CW'(1);
            n_tcol  = CW'(1);
            n_run   = '0;
            n_cand  = '1;
            n_held  = 8'h00;
        end
    end

    assign o_rec_valid = (cnt != 2'd0);
    assign o_rec.two   = (cnt == 2'd2);
    assign o_rec.tok0  = toks[0];
    assign o_rec.tok1  = toks[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_seen  <= 1'b0;
            r_line  <= CW'(1);
            r_col   <= CW'(1);
            r_tline <= CW'(1);
            r_tcol  <= CW'(1);
            r_run   <= '0;
            r_cand  <= '1;
            r_held  <= 8'h00;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_seen  <= n_seen;
            r_line  <= n_line;
            r_col   <= n_col;
            r_tline <= n_tline;
            r_tcol  <= n_tcol;
            r_run   <= n_run;
            r_cand  <= n_cand;
            r_held  <= n_held;
        end
    end

endmodule

// File: sv/stt_queue.sv
module stt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  stt_pkg::t_record i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output stt_pkg::t_record o_data
);

    stt_pkg::t_record                 r_mem [stt_pkg::QUEUE_DEPTH];
    logic [stt_pkg::QPTR_W-1:0]       r_wr, r_rd;
    logic [stt_pkg::QCNT_W-1:0]       r_cnt;
    logic                             do_push, do_pop;

    assign o_full  = (r_cnt == stt_pkg::QCNT_W'(stt_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + stt_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + stt_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + stt_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - stt_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

// File: sv/stt_back.sv
module stt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rec_empty,
    input  stt_pkg::t_record i_rec,
    output logic             o_rec_pop,
    output logic             o_empty,
    input  logic             i_pop,
    output stt_pkg::t_token  o_token,
    output logic             o_last
);

    logic            r_valid;
    logic            r_sel;
    logic            r_last;
    stt_pkg::t_token r_token;
    logic            load;
    logic            last_one;

    // The output register takes a new token when it is free or being drained.
    assign load      = (!r_valid || i_pop) && !i_rec_empty;
    assign last_one  = r_sel || !i_rec.two;
    assign o_rec_pop = load && last_one;

    assign o_empty = !r_valid;
    assign o_token = r_token;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sel   <= !last_one;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_token <= r_sel ? i_rec.tok1 : i_rec.tok0;
            r_last  <= last_one;
        end
    end

endmodule

// File: sv/source_text_tokenizer.sv
// Streaming lexer: one source byte per transfer in, one token per transfer out.
// Input channel: a byte (i_character) and an end-of-text flag are transferred
// at a clock edge where push is high and full is low. A byte may arrive every
// cycle. The front end classifies it, tracks line and column, and writes the
// zero, one or two tokens it completes into a four-entry record queue.
// Output channel: while empty is low the oldest token sits on the o_ ports
// and is transferred at an edge where pop is high. o_last_of_run marks the
// last token caused by one byte.
// A token completed by a byte is queued at the edge that transfers the byte
// and loaded into the output register once it is free. Throughput: one byte
// per cycle in while full is low, one token per cycle out while pop is high;
// a two-token byte holds the output register for both, the output-side limit.
// When the receiver stalls, the output register holds its token and the queue
// fills; full rises once four records wait, and the front end then holds.
// Operators are held for one byte to detect two-byte forms, so they appear one
// byte later. End of text flushes any pending token and returns the scanner
// to its reset state. Reset (synchronous, active low) empties the queue and
// output register and sets line and column to 1.
module source_text_tokenizer #(
    parameter int COUNT_WIDTH = stt_pkg::COUNT_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_character,
    input  logic        i_end_of_text,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_token_kind,
    output logic [7:0]  o_first_char,
    output logic [7:0]  o_second_char,
    output logic [15:0] o_token_length,
    output logic [15:0] o_start_line,
    output logic [15:0] o_start_column,
    output logic        o_last_of_run
);

    logic             accept;
    logic             rec_valid;
    stt_pkg::t_record front_rec;
    stt_pkg::t_record head_rec;
    logic             q_empty;
    logic             q_pop;
    stt_pkg::t_token  out_tok;

    assign accept = push && !full;

    stt_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_character   (i_character),
        .i_end_of_text (i_end_of_text),
        .o_rec_valid   (rec_valid),
        .o_rec         (front_rec)
    );

    // Bytes that complete no token write nothing into the queue.
    stt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && rec_valid),
        .i_data  (front_rec),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (head_rec)
    );

    stt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_empty (q_empty),
        .i_rec       (head_rec),
        .o_rec_pop   (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_token     (out_tok),
        .o_last      (o_last_of_run)
    );

    assign o_token_kind   = out_tok.kind;
    assign o_first_char   = out_tok.first;
    assign o_second_char  = out_tok.second;
    assign o_token_length = out_tok.length;
    assign o_start_line   = out_tok.line;
    assign o_start_column = out_tok.column;

endmodule

// File: tb/sv/tokenizer_sb_pkg.sv
package tokenizer_sb_pkg;

    import stt_pkg::*;

    // One token as it leaves the block, in port order.
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  first;
        logic [7:0]  second;
        logic [15:0] length;
        logic [15:0] line;
        logic [15:0] column;
        logic        last;
    } lex_token_t;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_WORD,
        SCAN_DIGITS,
        SCAN_OPER
    } scan_e;

    function automatic logic alpha_byte(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic digit_byte(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic blank_byte(input logic [7:0] c);
        return c == " " || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic op_byte(input logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" ||
               c == "=" || c == "<" || c == ">";
    endfunction

    function automatic logic sym_byte(input logic [7:0] c);
        return c == "{" || c == "}" || c == "(" || c == ")" || c == ";";
    endfunction

    function automatic logic [15:0] bump16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic string token_text(input lex_token_t t);
        return $sformatf("kind=%0d first=%02h second=%02h len=%0d line=%0d col=%0d last=%0b",
                         t.kind, t.first, t.second, t.length, t.line, t.column, t.last);
    endfunction

    class token_scoreboard;
        lex_token_t  expected_q[$];
        int          mismatches;

        scan_e       mode;
        logic        seen;
        logic [15:0] line_no;
        logic [15:0] col_no;
        logic [15:0] tok_line;
        logic [15:0] tok_col;
        logic [15:0] run_len;
        logic [63:0] word;      // first eight bytes of a word, right-justified
        logic [7:0]  held;
        lex_token_t  step_q[$];

        function new();
            mismatches = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            mode     = SCAN_IDLE;
            seen     = 1'b0;
            line_no  = 16'd1;
            col_no   = 16'd1;
            tok_line = 16'd1;
            tok_col  = 16'd1;
            run_len  = 16'd0;
            word     = 64'd0;
            held     = 8'd0;
        endfunction

        function void emit(input logic [2:0] kind, input logic [7:0] first,
                           input logic [7:0] second, input logic [15:0] len,
                           input logic [15:0] ln, input logic [15:0] col);
            lex_token_t t;
            t.kind   = kind;
            t.first  = first;
            t.second = second;
            t.length = len;
            t.line   = ln;
            t.column = col;
            t.last   = 1'b0;
            step_q.insert(step_q.size(), t);
        endfunction

        // A word is a keyword only when its whole text matches one.
        function logic [2:0] word_kind();
            if (run_len > 16'd8) begin
                return KIND_IDENTIFIER;
            end
            case (word)
                "function":     return KIND_FUNCTION;
                "for", "while": return KIND_LOOP;
                "return", "if": return KIND_KEYWORD;
                default:        return KIND_IDENTIFIER;
            endcase
        endfunction

        function void flush();
            case (mode)
                SCAN_WORD:   emit(word_kind(), held, 8'd0, run_len, tok_line, tok_col);
                SCAN_DIGITS: emit(KIND_NUMBER, held, 8'd0, run_len, tok_line, tok_col);
                SCAN_OPER:   emit(KIND_OPERATOR, held, 8'd0, 16'd1, tok_line, tok_col);
                default: ;
            endcase
            mode = SCAN_IDLE;
        endfunction

        function void start_run(input scan_e m, input logic [7:0] c);
            mode     = m;
            held     = c;
            tok_line = line_no;
            tok_col  = col_no;
            run_len  = 16'd1;
            word     = {56'd0, c};
        endfunction

        // Works out the tokens that one accepted byte completes.
        function void note_byte(input logic [7:0] c, input logic eot);
            logic       taken;
            taken = 1'b0;
            step_q.delete();
            case (mode)
                SCAN_WORD: begin
                    if (alpha_byte(c) || c == CH_UNDERSCORE) begin
                        if (run_len < 16'd8) begin
                            word = {word[55:0], c};
                        end
                        run_len = bump16(run_len);
                        taken = 1'b1;
                    end else begin
                        flush();
                    end
                end
                SCAN_DIGITS: begin
                    if (digit_byte(c)) begin
                        run_len = bump16(run_len);
                        taken = 1'b1;
                    end else begin
                        flush();
                    end
                end
                SCAN_OPER: begin
                    if (c == CH_EQUAL || (c == held && (held == CH_PLUS || held == CH_MINUS))) begin
                        emit(KIND_OPERATOR, held, c, 16'd2, tok_line, tok_col);
                        mode = SCAN_IDLE;
                        taken = 1'b1;
                    end else begin
                        flush();
                    end
                end
                default: ;
            endcase

            if (!taken && !blank_byte(c)) begin
                if (alpha_byte(c)) begin
                    start_run(SCAN_WORD, c);
                end else if (digit_byte(c)) begin
                    start_run(SCAN_DIGITS, c);
                end else if (op_byte(c)) begin
                    start_run(SCAN_OPER, c);
                end else if (sym_byte(c)) begin
                    emit(KIND_SYMBOL, c, 8'd0, 16'd1, line_no, col_no);
                end else begin
                    emit(KIND_UNKNOWN, c, 8'd0, 16'd1, line_no, col_no);
                end
            end

            if (!blank_byte(c)) begin
                seen = 1'b1;
            end
            if (seen) begin
                if (c == CH_NEWLINE) begin
                    line_no = bump16(line_no);
                    col_no  = 16'd1;
                end else begin
                    col_no = bump16(col_no);
                end
            end

            if (eot) begin
                flush();
                clear_scan();
            end

            if (step_q.size() > 0) begin
                step_q[step_q.size() - 1].last = 1'b1;
            end
            foreach (step_q[i]) begin
                expected_q.insert(expected_q.size(), step_q[i]);
            end
        endfunction

        task report(input string msg);
            mismatches++;
            if (mismatches <= 40) begin
                $display("token mismatch: %s", msg);
            end
        endtask

        task check_token(input lex_token_t got);
            lex_token_t want;
            if (expected_q.size() == 0) begin
                report({"unexpected token ", token_text(got)});
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    report({"got ", token_text(got), " want ", token_text(want)});
                end
            end
        endtask
    endclass

endpackage

// File: tb/sv/tb.sv
// Testbench for the streaming tokenizer.
module tb;

    import stt_pkg::*;
    import tokenizer_sb_pkg::*;

    // Generous ceiling for the whole run, even when every byte completes two
    // tokens under the longest stalls.
    localparam int CYCLE_LIMIT  = 50_000;
    localparam int RANDOM_ITEMS = 700;
    // The last stretch of the run is sent with no idling on either side.
    localparam int QUIET_ITEMS  = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_character;
    logic        i_end_of_text;
    logic        empty;
    logic        pop;
    logic [2:0]  o_token_kind;
    logic [7:0]  o_first_char;
    logic [7:0]  o_second_char;
    logic [15:0] o_token_length;
    logic [15:0] o_start_line;
    logic [15:0] o_start_column;
    logic        o_last_of_run;

    token_scoreboard sb;

    // Idling switches for the two sides; the main process changes them per text.
    logic tx_idle = 1'b1;
    logic rx_idle = 1'b1;
    int   rx_hold = 0;
    int   cycles = 0;
    int   sent_items = 0;

    // The text being built, sent as a whole with end of text on its last byte.
    logic [7:0] text_q[$];

    string      word_list[9] = '{"function", "for", "while", "return", "if",
                                 "fo", "iff", "returns", "While"};
    logic [7:0] op_list[7]    = '{"+", "-", "*", "/", "=", "<", ">"};
    logic [7:0] sym_list[5]   = '{"{", "}", "(", ")", ";"};
    logic [7:0] blank_list[6] = '{8'h20, 8'h09, CH_NEWLINE, 8'h0B, 8'h0C, 8'h0D};
    logic [7:0] odd_list[8]   = '{8'h00, "#", "@", "!", ".", ",", 8'h7F, 8'h22};

    source_text_tokenizer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_character    (i_character),
        .i_end_of_text  (i_end_of_text),
        .empty          (empty),
        .pop            (pop),
        .o_token_kind   (o_token_kind),
        .o_first_char   (o_first_char),
        .o_second_char  (o_second_char),
        .o_token_length (o_token_length),
        .o_start_line   (o_start_line),
        .o_start_column (o_start_column),
        .o_last_of_run  (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hang guard. If the block stops producing, this ends the run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** source_text_tokenizer: FAILED **");
            $finish;
        end
    end

    // Every output transfer is checked against the oldest predicted token.
    // Outputs are read in the active region of the rising edge, so they hold
    // the values from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_token({o_token_kind, o_first_char, o_second_char, o_token_length,
                            o_start_line, o_start_column, o_last_of_run});
        end
    end

    // Receiver: pop is high by default and drops at random while receiver
    // idling is on.
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                pop <= 1'b0;
                rx_hold--;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                rx_hold = $urandom_range(0, 2);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Offers one byte from a falling edge and waits for its transfer. The
    // prediction is made at the edge where the transfer happens. The task
    // returns on the next falling edge, so back-to-back bytes keep push high.
    task automatic send_byte(input logic [7:0] c, input logic eot);
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        push          <= 1'b1;
        i_character   <= c;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_byte(c, eot);
        @(negedge i_clk);
    endtask

    // Sends the built text and counts every byte of it.
    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) begin
            send_byte(text_q[i], i == text_q.size() - 1);
            sent_items++;
        end
        text_q.delete();
    endtask

    function automatic void add_byte(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endfunction

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_byte(s[i]);
        end
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) == 0) begin
            return 8'($urandom_range(65, 90));
        end
        return 8'($urandom_range(97, 122));
    endfunction

    // Appends one token-like piece of text. Most pieces are well formed; a
    // share are near-miss keywords, odd bytes and fully random bytes.
    function automatic void add_token();
        int         pick;
        int         n;
        logic [7:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            add_str(word_list[$urandom_range(0, 8)]);
        end else if (pick < 35) begin
            add_byte(rand_letter());
            n = $urandom_range(0, 10);
            repeat (n) begin
                add_byte(($urandom_range(0, 4) == 0) ? CH_UNDERSCORE : rand_letter());
            end
        end else if (pick < 50) begin
            n = $urandom_range(1, 6);
            repeat (n) add_byte(8'($urandom_range(48, 57)));
        end else if (pick < 68) begin
            // A lone operator, a two-byte form, or two operators that do not pair.
            op = op_list[$urandom_range(0, 6)];
            add_byte(op);
            case ($urandom_range(0, 3))
                0: add_byte(CH_EQUAL);
                1: add_byte(op);
                2: add_byte(op_list[$urandom_range(0, 6)]);
                default: ;
            endcase
        end else if (pick < 80) begin
            add_byte(sym_list[$urandom_range(0, 4)]);
        end else if (pick < 90) begin
            case ($urandom_range(0, 2))
                0: add_byte(CH_UNDERSCORE);
                1: add_byte(8'($urandom_range(128, 255)));
                default: add_byte(odd_list[$urandom_range(0, 7)]);
            endcase
        end else begin
            add_byte(8'($urandom));
        end
    endfunction

    // Whitespace between pieces; often none, so that tokens run together.
    function automatic void add_gap();
        if ($urandom_range(0, 9) >= 3) begin
            repeat ($urandom_range(1, 3)) add_byte(blank_list[$urandom_range(0, 5)]);
        end
    endfunction

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_character   = 8'd0;
        i_end_of_text = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed texts. The first skips leading whitespace, names a function
        // and ends on two operators that do not pair, so the last byte flushes
        // two tokens at once.
        add_str(" \tfunction*/");
        send_text();
        // A word with an underscore that is not a keyword, a newline, a number
        // and an operator flushed by end of text.
        add_str("if_\n1>");
        send_text();
        // A loop, a keyword and symbols.
        add_str("for{if}");
        send_text();
        // The byte extremes and a lone underscore are all unknown tokens.
        text_q = '{8'h00, CH_UNDERSCORE, 8'hFF};
        send_text();

        // Random texts: mostly well-formed token streams with random content,
        // some pure noise. Idling on each side is switched per text, and the
        // last stretch of the run has none on either side.
        sent_items = 0;
        while (sent_items < RANDOM_ITEMS) begin
            if (sent_items < RANDOM_ITEMS - QUIET_ITEMS) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end else begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    add_gap();
                end
                repeat ($urandom_range(1, 16)) begin
                    add_token();
                    add_gap();
                end
            end
            send_text();
        end
        push <= 1'b0;

        // Drain, then keep watching for anything unexpected to show.
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("** source_text_tokenizer: PASSED **");
        end else begin
            $display("** source_text_tokenizer: FAILED **");
        end
        $finish;
    end

endmodule
